/* hw/rtl/rbc_pkg.sv */
// shared types and constants of the rgb box color classifier
// no dependencies; used by every module under hw/rtl
package rbc_pkg;

  // sample width of one color channel
  localparam int SAMPLE_BITS = 10;

  // six bounds per box: r_lo, r_hi, g_lo, g_hi, b_lo, b_hi from the lsb up
  localparam int NUM_BOUNDS = 6;
  localparam int BOX_BITS   = NUM_BOUNDS * SAMPLE_BITS;

  // box registers keep at most 64 bits, bounds above bit 63 read as zero
  localparam int STORE_BITS = (BOX_BITS > 64) ? 64 : BOX_BITS;

  // configuration port
  localparam int CFG_BITS   = BOX_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int COUNT_BITS = 4;
  localparam int NUM_BOXES  = 6;
  localparam int BOX_IDX_W  = 3;

  // register indexes; box registers 0..5 are also the box indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_OFF_TRACK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BLACK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WHITE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_RED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_GREEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_BLUE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT = 3'd6;

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_BLACK = 3'd1,
    CLS_WHITE = 3'd2,
    CLS_RED   = 3'd3,
    CLS_GREEN = 3'd4,
    CLS_BLUE  = 3'd5,
    CLS_OFF   = 3'd6
  } color_class_t;

  // one sample after the box compares
  typedef struct packed {
    logic                 valid;
    logic [NUM_BOXES-1:0] hit;
  } sample_hits_t;

  // zero-fill a stored box up to the full bound layout
  function automatic logic [BOX_BITS-1:0] box_widen(input logic [STORE_BITS-1:0] v);
    logic [BOX_BITS-1:0] w;
    w = '0;
    for (int i = 0; i < STORE_BITS; i++) begin
      w[i] = v[i];
    end
    return w;
  endfunction

  // class to box index: off-track lives in box 0, the others in their own code
  function automatic logic [BOX_IDX_W-1:0] box_of(input color_class_t cls);
    logic [BOX_IDX_W-1:0] idx;
    case (cls)
      CLS_OFF:   idx = REG_BOX_OFF_TRACK;
      CLS_BLACK: idx = REG_BOX_BLACK;
      CLS_WHITE: idx = REG_BOX_WHITE;
      CLS_RED:   idx = REG_BOX_RED;
      CLS_GREEN: idx = REG_BOX_GREEN;
      CLS_BLUE:  idx = REG_BOX_BLUE;
      default:   idx = REG_BOX_OFF_TRACK;
    endcase
    return idx;
  endfunction

endpackage

/* hw/rtl/rbc_box_match.sv */
// strict in-box test of one rgb sample against one packed box
// depends on rbc_pkg
module rbc_box_match (
  input  logic [rbc_pkg::BOX_BITS-1:0]    box,
  input  logic [rbc_pkg::SAMPLE_BITS-1:0] red,
  input  logic [rbc_pkg::SAMPLE_BITS-1:0] green,
  input  logic [rbc_pkg::SAMPLE_BITS-1:0] blue,
  output logic                            hit
);

  localparam int SB = rbc_pkg::SAMPLE_BITS;

  logic [SB-1:0] r_lo, r_hi, g_lo, g_hi, b_lo, b_hi;

  assign r_lo = box[0*SB +: SB];
  assign r_hi = box[1*SB +: SB];
  assign g_lo = box[2*SB +: SB];
  assign g_hi = box[3*SB +: SB];
  assign b_lo = box[4*SB +: SB];
  assign b_hi = box[5*SB +: SB];

  // both bounds strict on every channel
  assign hit = (red   > r_lo) && (red   < r_hi) &&
               (green > g_lo) && (green < g_hi) &&
               (blue  > b_lo) && (blue  < b_hi);

endmodule

/* hw/rtl/rbc_decide.sv */
// decision state (held class, match count) and the result register
// depends on rbc_pkg
module rbc_decide (
  input  logic                             clk,
  input  logic                             rst,
  input  rbc_pkg::sample_hits_t            sample,
  input  logic [rbc_pkg::COUNT_BITS-1:0]   confirm_count,
  output logic                             take,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       color_class
);

  rbc_pkg::color_class_t             held_class, held_class_next;
  logic [rbc_pkg::COUNT_BITS-1:0]    match_count, match_count_next;
  logic [rbc_pkg::COUNT_BITS-1:0]    need, count_inc;
  rbc_pkg::color_class_t             first_class, emit_class;
  logic                              emit, held_hit;

  // sample leaves the input register when the result register can take it
  assign take = sample.valid && (!out_valid || out_ready);

  assign need      = (confirm_count == '0) ? rbc_pkg::COUNT_BITS'(1) : confirm_count;
  assign count_inc = match_count + rbc_pkg::COUNT_BITS'(1);
  assign held_hit  = sample.hit[rbc_pkg::box_of(held_class)];

  // priority: off-track, black, white, red, green, blue
  always_comb begin
    if (sample.hit[rbc_pkg::REG_BOX_OFF_TRACK]) begin
      first_class = rbc_pkg::CLS_OFF;
    end else if (sample.hit[rbc_pkg::REG_BOX_BLACK]) begin
      first_class = rbc_pkg::CLS_BLACK;
    end else if (sample.hit[rbc_pkg::REG_BOX_WHITE]) begin
      first_class = rbc_pkg::CLS_WHITE;
    end else if (sample.hit[rbc_pkg::REG_BOX_RED]) begin
      first_class = rbc_pkg::CLS_RED;
    end else if (sample.hit[rbc_pkg::REG_BOX_GREEN]) begin
      first_class = rbc_pkg::CLS_GREEN;
    end else if (sample.hit[rbc_pkg::REG_BOX_BLUE]) begin
      first_class = rbc_pkg::CLS_BLUE;
    end else begin
      first_class = rbc_pkg::CLS_NONE;
    end
  end

  always_comb begin
    held_class_next  = held_class;
    match_count_next = match_count;
    emit             = 1'b0;
    emit_class       = rbc_pkg::CLS_NONE;
    if (held_class == rbc_pkg::CLS_NONE) begin
      if (first_class == rbc_pkg::CLS_NONE || need <= rbc_pkg::COUNT_BITS'(1)) begin
        emit       = 1'b1;
        emit_class = first_class;
      end else begin
        held_class_next  = first_class;
        match_count_next = rbc_pkg::COUNT_BITS'(1);
      end
    end else if (!held_hit) begin
      emit             = 1'b1;
      emit_class       = rbc_pkg::CLS_NONE;
      held_class_next  = rbc_pkg::CLS_NONE;
      match_count_next = '0;
    end else if (count_inc == '0 || count_inc >= need) begin
      // counter wrap also closes the decision
      emit             = 1'b1;
      emit_class       = held_class;
      held_class_next  = rbc_pkg::CLS_NONE;
      match_count_next = '0;
    end else begin
      match_count_next = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_class  <= rbc_pkg::CLS_NONE;
      match_count <= '0;
    end else if (take) begin
      held_class  <= held_class_next;
      match_count <= match_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      color_class <= emit_class;
    end
  end

  a_count_with_hold: assert property (@(posedge clk) disable iff (rst)
    (held_class != rbc_pkg::CLS_NONE) |-> (match_count != '0))
    else $error("decision held with zero match count");

  a_count_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (held_class == rbc_pkg::CLS_NONE) |-> (match_count == '0))
    else $error("match count nonzero with no decision");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (take && emit) |=> (out_valid && color_class == $past(emit_class)))
    else $error("result lost on transfer into output register");

  a_start_holds: assert property (@(posedge clk) disable iff (rst)
    (take && !emit && held_class == rbc_pkg::CLS_NONE) |=>
      (held_class != rbc_pkg::CLS_NONE))
    else $error("silent first sample did not open a decision");

endmodule

/* hw/rtl/rgb_box_color_classifier.sv */
// top level of the rgb box color classifier: config registers, input register,
// six box comparators and the decision stage; depends on rbc_pkg, rbc_box_match
// and rbc_decide
//
// The block takes one raw rgb sample per cycle and gives zero or one color
// class per sample. A sample is caught in the input register; in the next
// cycle it is compared against all six boxes at once and the decision stage
// either opens a decision, counts a confirming sample, or loads a result into
// the output register. A sample that gives a result puts it on the output in the
// cycle after its transfer, so the result passes the input and output registers
// before it transfers out; throughput is one sample per cycle, set by the
// single compare-and-decide stage between the input and result registers,
// and the input side stalls only while the output register holds a result
// that has not been taken. Box and confirm-count registers are written through
// cfg_write/cfg_index/cfg_data and should be changed only while no sample is
// in flight; an index beyond the confirm-count register is ignored.
module rgb_box_color_classifier (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [rbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbc_pkg::CFG_BITS-1:0]      cfg_data,
  // sample input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rbc_pkg::SAMPLE_BITS-1:0]   red,
  input  logic [rbc_pkg::SAMPLE_BITS-1:0]   green,
  input  logic [rbc_pkg::SAMPLE_BITS-1:0]   blue,
  // class output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        color_class
);

  // box registers, indexed by register index (off-track is box 0)
  logic [rbc_pkg::STORE_BITS-1:0]  box [rbc_pkg::NUM_BOXES];
  logic [rbc_pkg::COUNT_BITS-1:0]  confirm_count;

  // input register
  logic                            s1_valid;
  logic [rbc_pkg::SAMPLE_BITS-1:0] s1_red, s1_green, s1_blue;

  logic [rbc_pkg::NUM_BOXES-1:0]   hit;
  rbc_pkg::sample_hits_t           sample;
  logic                            take;

  // configuration writes, no wait states
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rbc_pkg::NUM_BOXES; i++) begin
        box[i] <= '0;
      end
      confirm_count <= rbc_pkg::COUNT_BITS'(1);
    end else if (cfg_write) begin
      for (int i = 0; i < rbc_pkg::NUM_BOXES; i++) begin
        if (cfg_index == rbc_pkg::CFG_IDX_W'(i)) begin
          box[i] <= cfg_data[rbc_pkg::STORE_BITS-1:0];
        end
      end
      if (cfg_index == rbc_pkg::REG_CONFIRM_COUNT) begin
        confirm_count <= cfg_data[rbc_pkg::COUNT_BITS-1:0];
      end
    end
  end

  // input register empties into the decision stage whenever that stage takes it
  assign in_ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_red   <= red;
      s1_green <= green;
      s1_blue  <= blue;
    end
  end

  // all six boxes compared in parallel
  for (genvar g = 0; g < rbc_pkg::NUM_BOXES; g++) begin : g_box
    rbc_box_match u_match (
      .box   (rbc_pkg::box_widen(box[g])),
      .red   (s1_red),
      .green (s1_green),
      .blue  (s1_blue),
      .hit   (hit[g])
    );
  end

  assign sample.valid = s1_valid;
  assign sample.hit   = hit;

  // held class, confirm counting and result register
  rbc_decide u_decide (
    .clk           (clk),
    .rst           (rst),
    .sample        (sample),
    .confirm_count (confirm_count),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .color_class   (color_class)
  );

endmodule

/* verif/tb_rgb_box_color_classifier.sv */
`timescale 1ns / 1ps
// testbench for rgb_box_color_classifier: directed and random rgb samples, each class
// checked against an in-bench class predictor; depends on rbc_pkg and the rtl top level
module tb_rgb_box_color_classifier;

  localparam int HALF_PERIOD = 6;
  localparam int SAMPLE_MAX = (1 << rbc_pkg::SAMPLE_BITS) - 1;
  localparam logic [rbc_pkg::SAMPLE_BITS-1:0] SAMPLE_TOP = '1;
  // index past the last register, the block must ignore it
  localparam logic [rbc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  // idle cycles after the last class so a sample with no class leaves the pipe
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT = 20000;
  localparam int ITEMS_PER_ROUND = 104;
  localparam longint TIMEOUT_NS = 3_000_000;

  // dut ports, all inputs known from time zero
  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [rbc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [rbc_pkg::CFG_BITS-1:0]       cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [rbc_pkg::SAMPLE_BITS-1:0]    red = '0;
  logic [rbc_pkg::SAMPLE_BITS-1:0]    green = '0;
  logic [rbc_pkg::SAMPLE_BITS-1:0]    blue = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [2:0]                         color_class;

  // predictor copy of the registers and of the decision state
  logic [rbc_pkg::BOX_BITS-1:0]       box_reg [rbc_pkg::NUM_BOXES];
  logic [rbc_pkg::COUNT_BITS-1:0]     confirm_reg = 4'd1;
  rbc_pkg::color_class_t              held_class = rbc_pkg::CLS_NONE;
  int                                 held_box = 0;
  logic [rbc_pkg::COUNT_BITS-1:0]     match_cnt = '0;

  // classes still owed by the block, oldest first
  rbc_pkg::color_class_t              pending_classes [$];
  rbc_pkg::color_class_t              front_class;

  int                                 fail_count = 0;
  int unsigned                        sent_count = 0;
  // percent of cycles the sender idles and the receiver stalls
  int unsigned                        send_idle_pct = 0;
  int unsigned                        take_stall_pct = 0;

  // search order of the first sample; entry i also uses box register i
  const rbc_pkg::color_class_t class_order [rbc_pkg::NUM_BOXES] =
    '{rbc_pkg::CLS_OFF, rbc_pkg::CLS_BLACK, rbc_pkg::CLS_WHITE, rbc_pkg::CLS_RED,
      rbc_pkg::CLS_GREEN, rbc_pkg::CLS_BLUE};

  rgb_box_color_classifier u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color_class (color_class)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    for (int k = 0; k < rbc_pkg::NUM_BOXES; k++) box_reg[k] = '0;
  end

  // ---------------------------------------------------------------------------
  // class predictor
  // ---------------------------------------------------------------------------

  // strict lo < v < hi on all three channels; bounds packed r_lo first from the lsb
  function automatic logic in_bounds(input logic [rbc_pkg::BOX_BITS-1:0] bx,
                                     input logic [rbc_pkg::SAMPLE_BITS-1:0] r, g, b);
    logic [rbc_pkg::SAMPLE_BITS-1:0] bnd [rbc_pkg::NUM_BOUNDS];
    for (int k = 0; k < rbc_pkg::NUM_BOUNDS; k++)
      bnd[k] = bx[k*rbc_pkg::SAMPLE_BITS +: rbc_pkg::SAMPLE_BITS];
    return (r > bnd[0]) && (r < bnd[1]) && (g > bnd[2]) && (g < bnd[3]) &&
           (b > bnd[4]) && (b < bnd[5]);
  endfunction

  // append one class to the owed list
  function automatic void owe_class(input rbc_pkg::color_class_t cls);
    pending_classes = {pending_classes, cls};
  endfunction

  // advance the decision state by one transferred sample, queue any class it gives
  function automatic void classify_sample(input logic [rbc_pkg::SAMPLE_BITS-1:0] r, g, b);
    rbc_pkg::color_class_t found;
    int hit_box;
    logic [rbc_pkg::COUNT_BITS-1:0] need;
    // a confirm count of zero acts like one
    need = (confirm_reg == 0) ? 4'd1 : confirm_reg;
    if (held_class == rbc_pkg::CLS_NONE) begin
      found = rbc_pkg::CLS_NONE;
      hit_box = 0;
      for (int i = 0; i < rbc_pkg::NUM_BOXES; i++) begin
        if (found == rbc_pkg::CLS_NONE && in_bounds(box_reg[i], r, g, b)) begin
          found = class_order[i];
          hit_box = i;
        end
      end
      if (found == rbc_pkg::CLS_NONE || need <= 1) begin
        owe_class(found);
      end else begin
        // decision opens, nothing reported yet
        held_class = found;
        held_box = hit_box;
        match_cnt = 4'd1;
      end
    end else if (!in_bounds(box_reg[held_box], r, g, b)) begin
      // a miss ends the decision with none
      held_class = rbc_pkg::CLS_NONE;
      match_cnt = '0;
      owe_class(rbc_pkg::CLS_NONE);
    end else begin
      match_cnt = match_cnt + 4'd1;
      // reaching or passing the count confirms, also after a count change
      if (match_cnt == 0 || match_cnt >= need) begin
        owe_class(held_class);
        held_class = rbc_pkg::CLS_NONE;
        match_cnt = '0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // class checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_classes.size() == 0) begin
        $display("%0t: class transfer with nothing owed, expected none actual %0d",
                 $time, color_class);
        fail_count++;
      end else begin
        front_class = pending_classes.pop_front();
        if (color_class !== front_class) begin
          $display("%0t: color_class mismatch, expected %0d (%s) actual %0d",
                   $time, front_class, front_class.name(), color_class);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= take_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // shared driving tasks, always entered at a rising edge
  // ---------------------------------------------------------------------------

  // one sample transfer; valid stays up across back-to-back samples
  task automatic send_rgb(input logic [rbc_pkg::SAMPLE_BITS-1:0] r, g, b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    classify_sample(r, g, b);
    sent_count++;
  endtask

  // stop sending, let every owed class arrive, then let the pipe empty
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_classes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(input logic [rbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rbc_pkg::CFG_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx < rbc_pkg::NUM_BOXES) box_reg[idx] = val;
    else if (idx == rbc_pkg::REG_CONFIRM_COUNT) confirm_reg = val[rbc_pkg::COUNT_BITS-1:0];
  endtask

  function automatic logic [rbc_pkg::BOX_BITS-1:0] pack_box(
      input logic [rbc_pkg::SAMPLE_BITS-1:0] r_lo, r_hi, g_lo, g_hi, b_lo, b_hi);
    return {b_hi, b_lo, g_hi, g_lo, r_hi, r_lo};
  endfunction

  // channel value mostly strictly inside lo..hi, sometimes on a bound or anywhere
  function automatic logic [rbc_pkg::SAMPLE_BITS-1:0] pick_channel(
      input logic [rbc_pkg::SAMPLE_BITS-1:0] lo, hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 96 && int'(hi) > int'(lo) + 1)
      return rbc_pkg::SAMPLE_BITS'($urandom_range(int'(hi) - 1, int'(lo) + 1));
    if (roll < 98) begin
      case ($urandom_range(3))
        0: return lo;
        1: return hi;
        2: return lo + 1'b1;
        default: return hi - 1'b1;
      endcase
    end
    return rbc_pkg::SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // after reset every box is empty, so each sample answers none at once
  task automatic test_reset_state();
    send_rgb('0, '0, '0);
    send_rgb(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP);
    send_rgb(1, 1, 1);
    drain_results();
  endtask

  // overlapping boxes with confirm count one: search order, strict bounds, extremes
  task automatic test_box_order();
    write_reg(rbc_pkg::REG_BOX_OFF_TRACK, pack_box(0, SAMPLE_TOP, 0, 100, 0, 100));
    write_reg(rbc_pkg::REG_BOX_BLACK, pack_box(0, 200, 0, 200, 0, 200));
    write_reg(rbc_pkg::REG_BOX_WHITE,
              pack_box(800, SAMPLE_TOP, 800, SAMPLE_TOP, 800, SAMPLE_TOP));
    write_reg(rbc_pkg::REG_BOX_RED, pack_box(500, SAMPLE_TOP, 0, 300, 0, 300));
    write_reg(rbc_pkg::REG_BOX_GREEN, pack_box(0, 300, 500, SAMPLE_TOP, 0, 300));
    write_reg(rbc_pkg::REG_BOX_BLUE, pack_box(0, 300, 0, 300, 500, SAMPLE_TOP));
    write_reg(rbc_pkg::REG_CONFIRM_COUNT, rbc_pkg::CFG_BITS'(1));
    // a write past the last register must change nothing
    write_reg(REG_UNMAPPED, '1);
    send_rgb(50, 50, 50);        // off-track wins over black
    send_rgb(150, 150, 150);     // black
    send_rgb(900, 900, 900);     // white
    send_rgb(700, 100, 100);     // green bound of off-track is exclusive, red
    send_rgb(100, 700, 100);     // green
    send_rgb(100, 100, 700);     // blue
    send_rgb(SAMPLE_TOP - 1'b1, SAMPLE_TOP - 1'b1, SAMPLE_TOP - 1'b1);
    send_rgb(SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP);   // on the upper bound, none
    send_rgb(0, 0, 0);           // on the lower bound, none
    send_rgb(1, 1, 1);
    send_rgb(500, 150, 150);     // between boxes, none
    drain_results();
  endtask

  // confirm counting: silent confirming samples, a miss, count zero, count changed
  // while a decision is open
  task automatic test_confirm_rules();
    write_reg(rbc_pkg::REG_CONFIRM_COUNT, rbc_pkg::CFG_BITS'(3));
    repeat (3) send_rgb(150, 150, 150);
    send_rgb(150, 150, 150);
    send_rgb(900, 900, 900);     // leaves the black box, none
    drain_results();
    write_reg(rbc_pkg::REG_CONFIRM_COUNT, rbc_pkg::CFG_BITS'(0));
    send_rgb(900, 900, 900);
    drain_results();
    write_reg(rbc_pkg::REG_CONFIRM_COUNT, rbc_pkg::CFG_BITS'(5));
    repeat (2) send_rgb(100, 100, 700);
    drain_results();
    // decision holds two matches, the third passes the new count
    write_reg(rbc_pkg::REG_CONFIRM_COUNT, rbc_pkg::CFG_BITS'(2));
    send_rgb(100, 100, 700);
    drain_results();
  endtask

  // new random boxes, with empty, all-ones and full-range ones mixed in
  task automatic shuffle_settings(input logic [rbc_pkg::COUNT_BITS-1:0] confirm);
    logic [rbc_pkg::BOX_BITS-1:0] bx;
    int unsigned lo, hi;
    for (int k = 0; k < rbc_pkg::NUM_BOXES; k++) begin
      case ($urandom_range(9))
        0: bx = '0;
        1: bx = '1;
        2: bx = pack_box(0, SAMPLE_TOP, 0, SAMPLE_TOP, 0, SAMPLE_TOP);
        default: begin
          for (int c = 0; c < 3; c++) begin
            lo = $urandom_range(SAMPLE_MAX - 2);
            hi = lo + $urandom_range(300);
            if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
            bx[2*c*rbc_pkg::SAMPLE_BITS +: rbc_pkg::SAMPLE_BITS] =
              rbc_pkg::SAMPLE_BITS'(lo);
            bx[(2*c+1)*rbc_pkg::SAMPLE_BITS +: rbc_pkg::SAMPLE_BITS] =
              rbc_pkg::SAMPLE_BITS'(hi);
          end
        end
      endcase
      write_reg(rbc_pkg::CFG_IDX_W'(k), bx);
    end
    write_reg(rbc_pkg::REG_CONFIRM_COUNT, rbc_pkg::CFG_BITS'(confirm));
  endtask

  // runs of samples aimed at one box, long enough to confirm, some cut short,
  // with noise samples and full pauses in between
  task automatic run_round(input logic [rbc_pkg::COUNT_BITS-1:0] confirm);
    localparam int SB = rbc_pkg::SAMPLE_BITS;
    int unsigned target, k, need, len;
    logic [rbc_pkg::BOX_BITS-1:0] bx;
    drain_results();
    shuffle_settings(confirm);
    need = (confirm == 0) ? 1 : int'(confirm);
    target = sent_count + ITEMS_PER_ROUND;
    while (sent_count < target) begin
      k = $urandom_range(rbc_pkg::NUM_BOXES - 1);
      bx = box_reg[k];
      len = ($urandom_range(9) == 0) ? $urandom_range(need, 1) : need;
      for (int i = 0; i < len; i++) begin
        send_rgb(pick_channel(bx[0*SB +: SB], bx[1*SB +: SB]),
                 pick_channel(bx[2*SB +: SB], bx[3*SB +: SB]),
                 pick_channel(bx[4*SB +: SB], bx[5*SB +: SB]));
      end
      if ($urandom_range(99) < 8)
        send_rgb(SB'($urandom_range(SAMPLE_MAX)), SB'($urandom_range(SAMPLE_MAX)),
                 SB'($urandom_range(SAMPLE_MAX)));
      // sender holds off until every owed class is in
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  // three idling modes, each through confirm counts one, middling, fifteen and zero
  task automatic test_random_traffic();
    logic [rbc_pkg::COUNT_BITS-1:0] confirm_picks [4];
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 35; take_stall_pct = 68; end
        1: begin send_idle_pct = 68; take_stall_pct = 35; end
        default: begin send_idle_pct = 0; take_stall_pct = 0; end
      endcase
      confirm_picks[0] = 4'd1;
      confirm_picks[1] = rbc_pkg::COUNT_BITS'($urandom_range(6, 2));
      confirm_picks[2] = 4'd15;
      confirm_picks[3] = 4'd0;
      for (int r = 0; r < 4; r++) run_round(confirm_picks[r]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct = 35;
    take_stall_pct = 68;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_box_order();
    test_confirm_rules();
    test_random_traffic();
    drain_results();
    if (pending_classes.size() != 0) begin
      $display("%0t: %0d expected classes never arrived, next expected %0d",
               $time, pending_classes.size(), pending_classes[0]);
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest passing run
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
